// ----- rtl/delta_run_length_decoder_defines.svh -----
// Assertion macros for the delta run-length decoder checks
`ifndef DELTA_RUN_LENGTH_DECODER_DEFINES_SVH
`define DELTA_RUN_LENGTH_DECODER_DEFINES_SVH

// checked outside reset only
`define DRLD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define DRLD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/drld_pkg.sv -----
// Shared types, codes and constants of the delta run-length decoder
`default_nettype none

package drld_pkg;

	localparam int unsigned CONFIRM_BYTES_DEF = 8;
	localparam int unsigned QUEUE_DEPTH       = 2;
	localparam int unsigned CAP_W             = 24;
	localparam int unsigned COUNT_W           = 32;

	localparam logic [1:0] CMD_BYTE    = 2'd0;
	localparam logic [1:0] CMD_PULL    = 2'd1;
	localparam logic [1:0] CMD_END     = 2'd2;
	localparam logic [1:0] CMD_RESTART = 2'd3;

	localparam logic [2:0] ST_BUSY     = 3'd0;
	localparam logic [2:0] ST_OK       = 3'd1;
	localparam logic [2:0] ST_TRUNC    = 3'd2;
	localparam logic [2:0] ST_OVERRUN  = 3'd3;
	localparam logic [2:0] ST_MISMATCH = 3'd4;

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_PULL,
		OP_END,
		OP_RESTART
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} q_entry_t;

endpackage

`default_nettype wire

// ----- rtl/drld_if.sv -----
// Word channel interfaces: compressed input, decoded result and capacity write
`default_nettype none

interface drld_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] in_byte;

	modport source(output valid, cmd, in_byte, input ready);
	modport sink(input valid, cmd, in_byte, output ready);
endinterface

interface drld_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        out_valid;
	logic        byte_taken;
	logic [2:0]  decode_status;
	logic [31:0] bytes_consumed;

	modport source(output valid, out_byte, out_valid, byte_taken, decode_status,
		bytes_consumed, input ready);
	modport sink(input valid, out_byte, out_valid, byte_taken, decode_status,
		bytes_consumed, output ready);
endinterface

interface drld_cfg_if;
	logic        valid;
	logic        ready;
	logic [23:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/drld_front.sv -----
// Front end: takes input words and classifies the command into a queue entry
`default_nettype none

module drld_front (
	drld_in_if.sink           in_ch,
	input  wire logic         q_ready,
	output logic              q_push,
	output drld_pkg::q_entry_t q_wdata
);

	drld_pkg::op_t op;

	always_comb begin
		case (in_ch.cmd)
			drld_pkg::CMD_BYTE:    op = drld_pkg::OP_BYTE;
			drld_pkg::CMD_PULL:    op = drld_pkg::OP_PULL;
			drld_pkg::CMD_END:     op = drld_pkg::OP_END;
			drld_pkg::CMD_RESTART: op = drld_pkg::OP_RESTART;
			default:               op = drld_pkg::OP_RESTART;
		endcase
	end

	assign in_ch.ready  = q_ready;
	assign q_push       = in_ch.valid && q_ready;
	assign q_wdata.op   = op;
	// byte only matters for byte commands
	assign q_wdata.data = (op == drld_pkg::OP_BYTE) ? in_ch.in_byte : 8'd0;

endmodule

`default_nettype wire

// ----- rtl/drld_fifo.sv -----
// Short queue between front and back end
`default_nettype none

module drld_fifo #(
	parameter int unsigned DEPTH = drld_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire drld_pkg::q_entry_t wdata,
	output logic                    ready,
	input  wire logic               pop,
	output logic                    not_empty,
	output drld_pkg::q_entry_t      rdata
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	drld_pkg::q_entry_t mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign ready     = (count_q != CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= ptr_inc(wptr_q);
			if (pop)
				rptr_q <= ptr_inc(rptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

endmodule

`default_nettype wire

// ----- rtl/drld_back.sv -----
// Back end: decode state machine, capacity register and result register
`default_nettype none

module drld_back #(
	parameter int unsigned CONFIRM_BYTES = drld_pkg::CONFIRM_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_not_empty,
	input  wire drld_pkg::q_entry_t q_rdata,
	output logic                    q_pop,
	drld_cfg_if.sink                cfg,
	drld_out_if.source              out_ch
);

	localparam int unsigned WW  = 8 * CONFIRM_BYTES;
	localparam int unsigned CIW = $clog2(CONFIRM_BYTES);

	typedef enum logic [2:0] {
		PH_HDR_LO,
		PH_HDR_HI,
		PH_RAW,
		PH_DELTA,
		PH_VALUE,
		PH_EMIT,
		PH_CONFIRM,
		PH_DONE
	} phase_t;

	phase_t       phase_q, phase_d;
	logic [7:0]   hdr_lo_q, hdr_lo_d;
	logic [15:0]  rem_q, rem_d;
	logic [7:0]   delta_q, delta_d;
	logic [7:0]   value_q, value_d;
	logic [23:0]  produced_q, produced_d;
	logic [31:0]  consumed_q, consumed_d;
	logic [WW-1:0] confirm_q, confirm_d;
	logic [CIW-1:0] cidx_q, cidx_d;
	logic [2:0]   status_q, status_d;
	logic [23:0]  cap_q;

	logic         oval_q;
	logic [7:0]   obyte_q, obyte_d;
	logic         oflag_q, oflag_d;
	logic         otaken_q, otaken_d;

	logic [14:0]  len;
	logic [15:0]  emit;
	logic [24:0]  sum;
	logic [WW-1:0] word_new;
	logic [7:0]   b;

	assign cfg.ready     = 1'b1;
	assign q_pop         = q_not_empty && (!oval_q || out_ch.ready);
	assign b             = q_rdata.data;
	assign len           = {b[6:0], hdr_lo_q};
	assign emit          = {1'b0, len} + 16'(b[7]);
	assign sum           = {1'b0, produced_q} + 25'(emit);
	assign word_new      = {b, confirm_q[WW-1:8]};

	always_comb begin
		phase_d    = phase_q;
		hdr_lo_d   = hdr_lo_q;
		rem_d      = rem_q;
		delta_d    = delta_q;
		value_d    = value_q;
		produced_d = produced_q;
		consumed_d = consumed_q;
		confirm_d  = confirm_q;
		cidx_d     = cidx_q;
		status_d   = status_q;
		obyte_d    = 8'd0;
		oflag_d    = 1'b0;
		otaken_d   = 1'b0;
		case (q_rdata.op)
			drld_pkg::OP_RESTART: begin
				phase_d    = PH_HDR_LO;
				hdr_lo_d   = '0;
				rem_d      = '0;
				delta_d    = '0;
				value_d    = '0;
				produced_d = '0;
				consumed_d = '0;
				confirm_d  = '0;
				cidx_d     = '0;
				status_d   = drld_pkg::ST_BUSY;
			end
			drld_pkg::OP_END: begin
				if (phase_q != PH_DONE) begin
					status_d = drld_pkg::ST_TRUNC;
					phase_d  = PH_DONE;
				end
			end
			drld_pkg::OP_PULL: begin
				if (phase_q == PH_EMIT) begin
					obyte_d    = value_q;
					oflag_d    = 1'b1;
					value_d    = value_q + delta_q;
					produced_d = produced_q + 24'd1;
					rem_d      = rem_q - 16'd1;
					if (rem_q == 16'd1)
						phase_d = PH_HDR_LO;
				end
			end
			drld_pkg::OP_BYTE: begin
				if (phase_q != PH_EMIT && phase_q != PH_DONE) begin
					otaken_d = 1'b1;
					case (phase_q)
						PH_HDR_LO: begin
							hdr_lo_d = b;
							phase_d  = PH_HDR_HI;
						end
						PH_HDR_HI: begin
							consumed_d = consumed_q + 32'd2;
							if (len == '0) begin
								confirm_d = '0;
								cidx_d    = '0;
								phase_d   = PH_CONFIRM;
							end else if (sum > {1'b0, cap_q}) begin
								status_d = drld_pkg::ST_OVERRUN;
								phase_d  = PH_DONE;
							end else begin
								rem_d   = emit;
								phase_d = b[7] ? PH_DELTA : PH_RAW;
							end
						end
						PH_RAW: begin
							obyte_d    = b;
							oflag_d    = 1'b1;
							consumed_d = consumed_q + 32'd1;
							produced_d = produced_q + 24'd1;
							rem_d      = rem_q - 16'd1;
							if (rem_q == 16'd1)
								phase_d = PH_HDR_LO;
						end
						PH_DELTA: begin
							delta_d = b;
							phase_d = PH_VALUE;
						end
						PH_VALUE: begin
							value_d    = b;
							consumed_d = consumed_q + 32'd2;
							phase_d    = PH_EMIT;
						end
						PH_CONFIRM: begin
							confirm_d = word_new;
							cidx_d    = cidx_q + CIW'(1);
							if (cidx_q == CIW'(CONFIRM_BYTES - 1)) begin
								phase_d  = PH_DONE;
								status_d = (word_new == WW'(consumed_q)) ?
									drld_pkg::ST_OK : drld_pkg::ST_MISMATCH;
							end
						end
						default: begin
							otaken_d = 1'b0;
						end
					endcase
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR_LO;
			hdr_lo_q   <= '0;
			rem_q      <= '0;
			delta_q    <= '0;
			value_q    <= '0;
			produced_q <= '0;
			consumed_q <= '0;
			confirm_q  <= '0;
			cidx_q     <= '0;
			status_q   <= drld_pkg::ST_BUSY;
			cap_q      <= '1;
			oval_q     <= 1'b0;
			obyte_q    <= '0;
			oflag_q    <= 1'b0;
			otaken_q   <= 1'b0;
		end else begin
			if (cfg.valid)
				cap_q <= cfg.data;
			if (q_pop) begin
				phase_q    <= phase_d;
				hdr_lo_q   <= hdr_lo_d;
				rem_q      <= rem_d;
				delta_q    <= delta_d;
				value_q    <= value_d;
				produced_q <= produced_d;
				consumed_q <= consumed_d;
				confirm_q  <= confirm_d;
				cidx_q     <= cidx_d;
				status_q   <= status_d;
				obyte_q    <= obyte_d;
				oflag_q    <= oflag_d;
				otaken_q   <= otaken_d;
				oval_q     <= 1'b1;
			end else if (out_ch.ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid          = oval_q;
	assign out_ch.out_byte       = obyte_q;
	assign out_ch.out_valid      = oflag_q;
	assign out_ch.byte_taken     = otaken_q;
	assign out_ch.decode_status  = status_q;
	assign out_ch.bytes_consumed = consumed_q;

endmodule

`default_nettype wire

// ----- rtl/delta_run_length_decoder.sv -----
// Top level of the delta run-length decoder
// Every input word (byte, pull, end or restart) yields exactly one result word, in order.
// One word is taken per clock when the output side keeps up. A word taken at the input
// sits in the two-entry command queue until the decode stage pops it; the decode stage's
// state update then writes the result register, and that update sets the rate. The queue
// and the result register let input and output stall independently. The capacity register
// may be written at any time but should only change while no decoding is outstanding.
`default_nettype none

module delta_run_length_decoder #(
	parameter int unsigned CONFIRM_BYTES = drld_pkg::CONFIRM_BYTES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	drld_in_if.sink    in_ch,
	drld_out_if.source out_ch,
	drld_cfg_if.sink   cfg
);

	logic               q_push;
	logic               q_ready;
	logic               q_pop;
	logic               q_not_empty;
	drld_pkg::q_entry_t q_wdata;
	drld_pkg::q_entry_t q_rdata;

	drld_front u_front (
		.in_ch   (in_ch),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	drld_fifo #(
		.DEPTH(drld_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.ready     (q_ready),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rdata     (q_rdata)
	);

	drld_back #(
		.CONFIRM_BYTES(CONFIRM_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.cfg         (cfg),
		.out_ch      (out_ch)
	);

endmodule

`default_nettype wire

// ----- rtl/drld_checker.sv -----
// Port-level checks of the decoder result channel, bound to the top level
`default_nettype none
`include "delta_run_length_decoder_defines.svh"

module drld_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_vld,
	input wire logic        out_rdy,
	input wire logic [7:0]  out_byte,
	input wire logic        out_flag,
	input wire logic        byte_taken,
	input wire logic [2:0]  decode_status,
	input wire logic [31:0] bytes_consumed
);

	`DRLD_ASSERT(a_out_hold,
		out_vld && !out_rdy |=> out_vld && $stable(out_byte) && $stable(out_flag) &&
		$stable(byte_taken) && $stable(bytes_consumed) && $stable(decode_status),
		"result word changed while stalled")
	`DRLD_ASSERT(a_emit_busy,
		out_vld && out_flag |-> decode_status == drld_pkg::ST_BUSY,
		"decoded byte after decoding finished")
	`DRLD_ASSERT(a_no_byte_zero,
		out_vld && !out_flag |-> out_byte == 8'd0,
		"out_byte set without a decoded byte")
	`DRLD_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_vld, "result word shown during reset")

endmodule

bind delta_run_length_decoder drld_checker u_drld_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_vld        (out_ch.valid),
	.out_rdy        (out_ch.ready),
	.out_byte       (out_ch.out_byte),
	.out_flag       (out_ch.out_valid),
	.byte_taken     (out_ch.byte_taken),
	.decode_status  (out_ch.decode_status),
	.bytes_consumed (out_ch.bytes_consumed)
);

`default_nettype wire
